[hdl/biphase_space_remote_frame_encoder_assert.svh]
// Assertion macros used by the encoder's checker file.
`ifndef BIPHASE_SPACE_REMOTE_FRAME_ENCODER_ASSERT_SVH
`define BIPHASE_SPACE_REMOTE_FRAME_ENCODER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define BSRFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bsrfe assertion failed");

// Checked on every rising edge, reset included.
`define BSRFE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bsrfe assertion failed");

`endif

[hdl/bsrfe_pkg.sv]
// Shared constants and types of the biphase-space remote frame encoder.
package bsrfe_pkg;

    localparam int ID_BITS    = 16;
    localparam int KEY_BITS   = 7;
    localparam int FRAME_BITS = ID_BITS + KEY_BITS + 1;
    localparam int CFG_BITS   = 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_BIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 2'd3;

    localparam logic [CFG_BITS-1:0] RST_START_TICKS  = 8'd63;
    localparam logic [CFG_BITS-1:0] RST_FULL_BIT     = 8'd39;
    localparam logic [CFG_BITS-1:0] RST_HALF_BIT     = 8'd19;
    localparam logic [CFG_BITS-1:0] RST_REPEAT_COUNT = 8'd127;

    // Phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_BIT   = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SEND = 1'b1;

    typedef struct packed {
        logic [CFG_BITS-1:0] start_ticks;
        logic [CFG_BITS-1:0] full_bit_ticks;
        logic [CFG_BITS-1:0] half_bit_ticks;
        logic [CFG_BITS-1:0] repeat_count;
    } t_cfg;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic accepted;
        logic all_done;
    } t_res;

endpackage

[hdl/bsrfe_cfg.sv]
// Configuration register bank of the encoder.
module bsrfe_cfg
    import bsrfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]  i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_ticks    <= RST_START_TICKS;
            r_cfg.full_bit_ticks <= RST_FULL_BIT;
            r_cfg.half_bit_ticks <= RST_HALF_BIT;
            r_cfg.repeat_count   <= RST_REPEAT_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_TICKS:  r_cfg.start_ticks    <= i_cfg_data;
                CFG_FULL_BIT:     r_cfg.full_bit_ticks <= i_cfg_data;
                CFG_HALF_BIT:     r_cfg.half_bit_ticks <= i_cfg_data;
                CFG_REPEAT_COUNT: r_cfg.repeat_count   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/bsrfe_core.sv]
// Frame sequencer: state registers and the per-item next-state logic.
module bsrfe_core
    import bsrfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_func,
    input  logic [ID_BITS-1:0]  i_remote_id,
    input  logic [KEY_BITS-1:0] i_key_code,
    input  t_cfg                i_cfg,
    output t_res                o_res
);

    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [FRAME_BITS-1:0] r_copy, n_copy;
    logic [CFG_BITS-1:0]   r_count, n_count;
    logic [CFG_BITS-1:0]   r_frames, n_frames;
    logic                  r_line, n_line;
    logic [1:0]            r_phase, n_phase;
    logic                  r_armed, n_armed;

    logic                  busy;
    logic                  send;
    logic                  tick;
    logic                  period_end;
    logic                  done;
    logic [FRAME_BITS-1:0] shifted;
    logic [CFG_BITS-1:0]   count_inc;

    assign busy      = (r_phase == PH_START) || (r_phase == PH_BIT);
    assign send      = i_take && (i_func == FUNC_SEND) && !busy;
    assign tick      = i_take && (i_func == FUNC_TICK) && busy;
    assign shifted   = {r_shift[FRAME_BITS-2:0], 1'b0};
    assign count_inc = r_count + 1'b1;

    always_comb begin
        period_end = 1'b0;
        case (r_phase)
            PH_START: period_end = (r_count == i_cfg.start_ticks);
            PH_BIT:   period_end = (r_count == i_cfg.full_bit_ticks);
            default:  period_end = 1'b0;
        endcase
    end

    always_comb begin
        n_shift  = r_shift;
        n_copy   = r_copy;
        n_count  = r_count;
        n_frames = r_frames;
        n_line   = r_line;
        n_phase  = r_phase;
        n_armed  = r_armed;
        done     = 1'b0;
        if (send) begin
            n_copy   = {i_remote_id, i_key_code, 1'b1};
            n_shift  = {i_remote_id, i_key_code, 1'b1};
            n_frames = i_cfg.repeat_count;
            n_count  = '0;
            n_armed  = 1'b0;
            n_line   = 1'b1;
            n_phase  = PH_START;
        end else if (tick) begin
            if (period_end) begin
                n_count = '0;
                n_shift = shifted;
                // Only the closing mark left means the frame has been sent.
                if (shifted != '0) begin
                    n_line  = ~r_line;
                    n_phase = PH_BIT;
                    n_armed = !r_shift[FRAME_BITS-1] && (i_cfg.half_bit_ticks != '0);
                end else begin
                    n_armed = 1'b0;
                    if (r_frames == '0) begin
                        n_line  = 1'b0;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_frames = r_frames - 1'b1;
                        n_shift  = r_copy;
                        n_line   = 1'b1;
                        n_phase  = PH_START;
                    end
                end
            end else begin
                n_count = count_inc;
                if ((r_phase == PH_BIT) && r_armed && (count_inc == i_cfg.half_bit_ticks)) begin
                    n_line  = ~r_line;
                    n_armed = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= '0;
            r_copy   <= '0;
            r_count  <= '0;
            r_frames <= '0;
            r_line   <= 1'b0;
            r_phase  <= PH_IDLE;
            r_armed  <= 1'b0;
        end else begin
            r_shift  <= n_shift;
            r_copy   <= n_copy;
            r_count  <= n_count;
            r_frames <= n_frames;
            r_line   <= n_line;
            r_phase  <= n_phase;
            r_armed  <= n_armed;
        end
    end

    assign o_res.pin_level = n_line;
    assign o_res.busy_res  = (n_phase == PH_START) || (n_phase == PH_BIT);
    assign o_res.accepted  = send;
    assign o_res.all_done  = done;

endmodule

[hdl/biphase_space_remote_frame_encoder.sv]
// The result of an input transfer is in the output register in the cycle after the transfer.
// Throughput: one item per cycle; the input stays ready while the output register
// is empty or is being drained in the same cycle.
// Reset (synchronous, active low) empties the output register, idles the core's line
// register low and restores the configuration registers to their defaults.
module biphase_space_remote_frame_encoder
    import bsrfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [ID_BITS-1:0]   i_remote_id,
    input  logic [KEY_BITS-1:0]  i_key_code,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_pin_level,
    output logic                 o_busy_res,
    output logic                 o_accepted,
    output logic                 o_all_done,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]  i_cfg_data
);

    t_cfg cfg;
    t_res res;
    t_res r_res;
    logic r_out_valid;
    logic take;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    bsrfe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bsrfe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_func      (i_func),
        .i_remote_id (i_remote_id),
        .i_key_code  (i_key_code),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pin_level = r_res.pin_level;
    assign o_busy_res  = r_res.busy_res;
    assign o_accepted  = r_res.accepted;
    assign o_all_done  = r_res.all_done;

endmodule

[hdl/bsrfe_checker.sv]
// Port-level checker for the encoder and its bind to the top level.
`include "biphase_space_remote_frame_encoder_assert.svh"

module bsrfe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_pin_level,
    input logic o_busy_res,
    input logic o_accepted,
    input logic o_all_done
);

    // A result waiting to be taken keeps its contents.
    `BSRFE_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable({o_pin_level, o_busy_res, o_accepted, o_all_done}))

    // A taken send always leaves the line high and the block busy.
    `BSRFE_ASSERT(a_accept_starts, i_clk, i_rst_n, o_out_valid && o_accepted |-> o_busy_res && o_pin_level && !o_all_done)

    // The final frame ends with the line low and the block idle.
    `BSRFE_ASSERT(a_done_idles, i_clk, i_rst_n, o_out_valid && o_all_done |-> !o_busy_res && !o_pin_level)

    // Reset empties the output register.
    `BSRFE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind biphase_space_remote_frame_encoder bsrfe_checker u_bsrfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pin_level (o_pin_level),
    .o_busy_res  (o_busy_res),
    .o_accepted  (o_accepted),
    .o_all_done  (o_all_done)
);
